FILE: rtl/orse_pkg.sv
// ----------------------------------------------------------------------------
// orse_pkg: shared types and constants for the 1-Wire ROM search engine
// Phase codes, result actions, input function codes and the result word.
// ----------------------------------------------------------------------------
package orse_pkg;

    localparam logic [1:0] FN_START    = 2'd0;
    localparam logic [1:0] FN_PRESENCE = 2'd1;
    localparam logic [1:0] FN_PAIR     = 2'd2;

    localparam logic [6:0] ID_BITS_END    = 7'd65;
    localparam int         FAMILY_BITS    = 8;
    localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESENCE = 2'd1,
        PH_SEARCH   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_RESET   = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_FINISH  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [7:0]  command_byte;
        logic        direction;
        logic        found;
        logic [63:0] device_id;
        logic        no_more_devices;
        logic        last;
    } t_result;

    typedef struct packed {
        logic               ready;
        logic [FIFO_LW-1:0] level;
    } t_fifo_status;

endpackage

FILE: rtl/orse_core.sv
// ----------------------------------------------------------------------------
// orse_core: search state and per-word step logic
// Holds the ROM register and search progress; turns one accepted input word
// into up to two result words for the output queue.
// ----------------------------------------------------------------------------
module orse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_func,
    input  logic              i_first_search,
    input  logic [1:0]        i_presence_lows,
    input  logic              i_id_bit,
    input  logic              i_complement_bit,
    output logic [1:0]        o_push_cnt,
    output orse_pkg::t_result o_res0,
    output orse_pkg::t_result o_res1
);

    logic [63:0]      r_rom, n_rom;
    logic [6:0]       r_last_disc, n_last_disc;
    logic             r_last_dev, n_last_dev;
    logic [6:0]       r_bit_pos, n_bit_pos;
    logic [6:0]       r_last_zero, n_last_zero;
    orse_pkg::t_phase r_phase, n_phase;

    logic [6:0]  w_pos;
    logic [5:0]  w_idx;
    logic        w_dir;
    logic [6:0]  w_lz_new;
    logic [63:0] w_rom_new;
    logic        w_done;
    logic        w_fam_zero;
    logic        w_start_ldev;
    logic        w_both;

    assign w_pos = (r_bit_pos == 7'd0 || r_bit_pos > 7'd64) ? 7'd1 : r_bit_pos;
    assign w_idx = 6'(w_pos - 7'd1);
    assign w_both = i_id_bit & i_complement_bit;

    always_comb begin
        w_lz_new = r_last_zero;
        if (i_id_bit != i_complement_bit) begin
            w_dir = i_id_bit;
        end else begin
            if (w_pos < r_last_disc) begin
                w_dir = r_rom[w_idx];
            end else begin
                w_dir = (w_pos == r_last_disc);
            end
            if (!w_dir) begin
                w_lz_new = w_pos;
            end
        end
    end

    always_comb begin
        w_rom_new = r_rom;
        w_rom_new[w_idx] = w_dir;
    end

    assign w_done       = (7'(w_pos + 7'd1) == orse_pkg::ID_BITS_END);
    assign w_fam_zero   = (w_rom_new[orse_pkg::FAMILY_BITS-1:0] == '0);
    assign w_start_ldev = r_last_dev & ~i_first_search;

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_func == orse_pkg::FN_START) begin
                n_phase = w_start_ldev ? orse_pkg::PH_IDLE : orse_pkg::PH_PRESENCE;
            end else begin
                unique case (r_phase)
                    orse_pkg::PH_PRESENCE: begin
                        if (i_func == orse_pkg::FN_PRESENCE) begin
                            n_phase = (i_presence_lows == 2'd1) ? orse_pkg::PH_SEARCH
                                                                : orse_pkg::PH_IDLE;
                        end
                    end
                    orse_pkg::PH_SEARCH: begin
                        if (i_func == orse_pkg::FN_PAIR && (w_both || w_done)) begin
                            n_phase = orse_pkg::PH_IDLE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // data updates and result words
    always_comb begin
        n_rom       = r_rom;
        n_last_disc = r_last_disc;
        n_last_dev  = r_last_dev;
        n_bit_pos   = r_bit_pos;
        n_last_zero = r_last_zero;
        o_push_cnt  = 2'd0;

        o_res0                 = '0;
        o_res0.device_id       = r_rom;
        o_res0.no_more_devices = r_last_dev;
        o_res0.last            = 1'b1;
        o_res1                 = '0;
        o_res1.action          = orse_pkg::ACT_FINISH;
        o_res1.device_id       = w_rom_new;
        o_res1.last            = 1'b1;

        if (i_accept) begin
            case (i_func)
                orse_pkg::FN_START: begin
                    if (i_first_search) begin
                        n_last_disc = '0;
                        n_last_dev  = 1'b0;
                    end
                    n_bit_pos   = 7'd1;
                    n_last_zero = '0;
                    o_push_cnt  = 2'd1;
                    o_res0.action = w_start_ldev ? orse_pkg::ACT_FINISH
                                                 : orse_pkg::ACT_RESET;
                    o_res0.no_more_devices = w_start_ldev;
                end
                orse_pkg::FN_PRESENCE: begin
                    if (r_phase == orse_pkg::PH_PRESENCE) begin
                        o_push_cnt = 2'd1;
                        if (i_presence_lows != 2'd1) begin
                            n_last_disc = '0;
                            n_last_dev  = 1'b0;
                            o_res0.action          = orse_pkg::ACT_FINISH;
                            o_res0.no_more_devices = 1'b0;
                        end else begin
                            o_res0.action       = orse_pkg::ACT_COMMAND;
                            o_res0.command_byte = orse_pkg::SEARCH_ROM_CMD;
                        end
                    end
                end
                orse_pkg::FN_PAIR: begin
                    if (r_phase == orse_pkg::PH_SEARCH) begin
                        o_push_cnt = 2'd1;
                        if (w_both) begin
                            n_last_disc = '0;
                            n_last_dev  = 1'b0;
                            o_res0.action          = orse_pkg::ACT_FINISH;
                            o_res0.no_more_devices = 1'b0;
                        end else begin
                            n_rom       = w_rom_new;
                            n_last_zero = w_lz_new;
                            n_bit_pos   = 7'(w_pos + 7'd1);
                            o_res0.action    = orse_pkg::ACT_WRITE;
                            o_res0.direction = w_dir;
                            o_res0.device_id = w_rom_new;
                            if (w_done) begin
                                o_push_cnt  = 2'd2;
                                o_res0.last = 1'b0;
                                n_last_disc = w_lz_new;
                                n_last_dev  = r_last_dev | (w_lz_new == 7'd0);
                                if (w_fam_zero) begin
                                    n_last_disc = '0;
                                    n_last_dev  = 1'b0;
                                end
                                o_res1.found           = ~w_fam_zero;
                                o_res1.no_more_devices = n_last_dev;
                            end
                        end
                    end
                end
                default: o_push_cnt = 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom       <= '0;
            r_last_disc <= '0;
            r_last_dev  <= 1'b0;
            r_bit_pos   <= 7'd1;
            r_last_zero <= '0;
            r_phase     <= orse_pkg::PH_IDLE;
        end else begin
            r_rom       <= n_rom;
            r_last_disc <= n_last_disc;
            r_last_dev  <= n_last_dev;
            r_bit_pos   <= n_bit_pos;
            r_last_zero <= n_last_zero;
            r_phase     <= n_phase;
        end
    end

endmodule

FILE: rtl/orse_out_fifo.sv
// ----------------------------------------------------------------------------
// orse_out_fifo: result word queue
// Takes up to two result words per cycle, hands one per cycle downstream while i_pop is high.
// Ready while at least two entries are free.
// ----------------------------------------------------------------------------
module orse_out_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_cnt,
    input  orse_pkg::t_result      i_res0,
    input  orse_pkg::t_result      i_res1,
    input  logic                   i_pop,
    output logic                   o_valid,
    output orse_pkg::t_result      o_res,
    output orse_pkg::t_fifo_status o_status
);

    localparam int AW = orse_pkg::FIFO_AW;
    localparam int LW = orse_pkg::FIFO_LW;

    orse_pkg::t_result r_mem [orse_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [LW-1:0] r_level, n_level;
    logic          w_pop;
    logic [AW-1:0] w_wr1;

    assign o_valid = (r_level != '0);
    assign w_pop   = i_pop & o_valid;
    assign w_wr1   = AW'(r_wr + AW'(1));
    assign o_res   = r_mem[r_rd];

    assign o_status.ready = (r_level <= LW'(orse_pkg::FIFO_DEPTH - 2));
    assign o_status.level = r_level;

    always_comb begin
        n_wr    = AW'(r_wr + AW'(i_push_cnt));
        n_rd    = w_pop ? AW'(r_rd + AW'(1)) : r_rd;
        n_level = LW'(r_level + LW'(i_push_cnt) - LW'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

endmodule

FILE: rtl/onewire_rom_search_engine.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_engine: 1-Wire ROM search sequencer
// Input stream words carry a function code in tuser and its operands in
// tdata: start (first or next search), presence result, or a sampled id /
// complement bit pair. Each word yields zero, one or two result words on the
// output stream: issue reset, send the 0xF0 command, write a direction slot,
// or search finished with found flag, ROM value and last-device flag. tlast
// marks the final result of an input word (the 64th bit pair gives a
// direction word followed by the finished word).
// Result words are registered in the output queue when the input word is taken.
// Throughput: one input word per cycle; the step logic is a single
// registered pass over the search state. Results wait in a four-entry queue;
// s_axis_tready drops while fewer than two entries are free, so a stalled
// receiver backs up the input side without loss.
// Reset (synchronous, active low) clears the ROM register, discrepancy,
// last-device flag and queue; bit position returns to one, phase to idle.
// Words out of phase (presence when not waiting, pairs when not searching)
// and unused function codes produce no result.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] first_search, [2:1] presence_lows, [3] id_bit, [4] complement_bit
    input  logic [7:0]  s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] command_byte, [8] direction, [9] found, [73:10] device_id,
    // [74] no_more_devices
    output logic [79:0] m_axis_tdata,
    // [1:0] action
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic                   w_accept;
    logic [1:0]             w_push_cnt;
    orse_pkg::t_result      w_res0;
    orse_pkg::t_result      w_res1;
    orse_pkg::t_result      w_out;
    orse_pkg::t_fifo_status w_status;

    assign s_axis_tready = w_status.ready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    orse_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_func           (s_axis_tuser),
        .i_first_search   (s_axis_tdata[0]),
        .i_presence_lows  (s_axis_tdata[2:1]),
        .i_id_bit         (s_axis_tdata[3]),
        .i_complement_bit (s_axis_tdata[4]),
        .o_push_cnt       (w_push_cnt),
        .o_res0           (w_res0),
        .o_res1           (w_res1)
    );

    orse_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_pop      (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_res      (w_out),
        .o_status   (w_status)
    );

    assign m_axis_tdata = {5'd0, w_out.no_more_devices, w_out.device_id, w_out.found,
                           w_out.direction, w_out.command_byte};
    assign m_axis_tuser = w_out.action;
    assign m_axis_tlast = w_out.last;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.level <= orse_pkg::FIFO_LW'(orse_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_pair_only_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_cnt == 2'd2) |-> (w_accept && s_axis_tuser == orse_pkg::FN_PAIR))
        else $error("two results from a word that is not a bit pair");

    a_mid_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == orse_pkg::ACT_WRITE))
        else $error("non-final result word is not a direction slot");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("result pending right after reset");
`endif

endmodule

FILE: tb/sv/rom_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_search_checker: result predictor and scoreboard for the ROM search engine
// Watches both stream channels. Each accepted input word runs through a local
// copy of the search state and queues the result words it should cause. Each
// accepted result word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module rom_search_checker
    import orse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,
    input  logic [1:0]  i_out_user,
    input  logic        i_out_last,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_answered_words,
    output int          o_results_checked,
    output int          o_ids_found
);

    localparam int PRINT_CAP = 40;

    logic [63:0] id_reg;
    logic [6:0]  disc_pos;
    logic        no_more;
    logic [6:0]  next_pos;
    logic [6:0]  zero_pos;
    t_phase      search_phase;

    t_result     search_results_due[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (o_mismatches < PRINT_CAP)
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic queue_result(input t_action act, input logic [7:0] cmd,
                                input logic dir, input logic hit, input logic tail);
        t_result r;
        r.action          = act;
        r.command_byte    = cmd;
        r.direction       = dir;
        r.found           = hit;
        r.device_id       = id_reg;
        r.no_more_devices = no_more;
        r.last            = tail;
        search_results_due.push_back(r);
    endtask

    task automatic abandon_search();
        disc_pos     = '0;
        no_more      = 1'b0;
        search_phase = PH_IDLE;
    endtask

    task automatic advance_search(input logic [1:0] fn, input logic [7:0] word);
        logic       first;
        logic [1:0] lows;
        logic       idb;
        logic       cmpb;
        logic       dir;
        logic [6:0] pos;
        int         queued;
        first  = word[0];
        lows   = word[2:1];
        idb    = word[3];
        cmpb   = word[4];
        queued = search_results_due.size();
        case (fn)
            FN_START: begin
                if (first) begin
                    disc_pos = '0;
                    no_more  = 1'b0;
                end
                next_pos = 7'd1;
                zero_pos = '0;
                if (no_more) begin
                    search_phase = PH_IDLE;
                    queue_result(ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1);
                end else begin
                    search_phase = PH_PRESENCE;
                    queue_result(ACT_RESET, 8'h00, 1'b0, 1'b0, 1'b1);
                end
            end
            FN_PRESENCE: begin
                if (search_phase == PH_PRESENCE) begin
                    if (lows != 2'd1) begin
                        abandon_search();
                        queue_result(ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1);
                    end else begin
                        search_phase = PH_SEARCH;
                        queue_result(ACT_COMMAND, SEARCH_ROM_CMD, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            FN_PAIR: begin
                if (search_phase == PH_SEARCH) begin
                    if (idb && cmpb) begin
                        abandon_search();
                        queue_result(ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1);
                    end else begin
                        pos = next_pos;
                        if (idb != cmpb) begin
                            dir = idb;
                        end else begin
                            if (pos < disc_pos)
                                dir = id_reg[6'(pos - 7'd1)];
                            else
                                dir = (pos == disc_pos);
                            if (!dir)
                                zero_pos = pos;
                        end
                        id_reg[6'(pos - 7'd1)] = dir;
                        next_pos = pos + 7'd1;
                        if (next_pos < ID_BITS_END) begin
                            queue_result(ACT_WRITE, 8'h00, dir, 1'b0, 1'b1);
                        end else begin
                            queue_result(ACT_WRITE, 8'h00, dir, 1'b0, 1'b0);
                            disc_pos = zero_pos;
                            if (disc_pos == '0)
                                no_more = 1'b1;
                            search_phase = PH_IDLE;
                            if (id_reg[FAMILY_BITS-1:0] == '0) begin
                                abandon_search();
                                queue_result(ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1);
                            end else begin
                                queue_result(ACT_FINISH, 8'h00, 1'b0, 1'b1, 1'b1);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (search_results_due.size() != queued)
            o_answered_words++;
    endtask

    task automatic check_result();
        t_result want;
        if (search_results_due.size() == 0) begin
            report_mismatch("result word with nothing expected, device_id",
                            i_out_data[73:10], 64'h0);
            return;
        end
        want = search_results_due.pop_front();
        o_results_checked++;
        if (want.found)
            o_ids_found++;
        if (i_out_user != want.action)
            report_mismatch("action", 64'(i_out_user), 64'(want.action));
        if (i_out_data[7:0] != want.command_byte)
            report_mismatch("command_byte", 64'(i_out_data[7:0]), 64'(want.command_byte));
        if (i_out_data[8] != want.direction)
            report_mismatch("direction", 64'(i_out_data[8]), 64'(want.direction));
        if (i_out_data[9] != want.found)
            report_mismatch("found", 64'(i_out_data[9]), 64'(want.found));
        if (i_out_data[73:10] != want.device_id)
            report_mismatch("device_id", i_out_data[73:10], want.device_id);
        if (i_out_data[74] != want.no_more_devices)
            report_mismatch("no_more_devices", 64'(i_out_data[74]),
                            64'(want.no_more_devices));
        if (i_out_last != want.last)
            report_mismatch("last", 64'(i_out_last), 64'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            id_reg       = '0;
            disc_pos     = '0;
            no_more      = 1'b0;
            next_pos     = 7'd1;
            zero_pos     = '0;
            search_phase = PH_IDLE;
            search_results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                advance_search(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_outstanding <= search_results_due.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ROM search engine
// Sends start, presence and bit-pair words: short directed cases first, then
// mostly complete 64-bit searches with random pair content, mixed with bad
// presence, broken-off and abandoned searches and out-of-phase noise. Both
// sides pause at random. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import orse_pkg::*;

    localparam int         LIMIT_CYCLES = 600000;
    localparam int         TARGET_WORDS = 1100;
    localparam logic [1:0] FN_SPARE     = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [79:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    wire         m_axis_tlast;

    int mismatches;
    int outstanding;
    int answered_words;
    int results_checked;
    int ids_found;
    int cycle_count = 0;
    int sink_hold = 0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    onewire_rom_search_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rom_search_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (s_axis_tvalid),
        .i_in_ready        (s_axis_tready),
        .i_in_data         (s_axis_tdata),
        .i_in_user         (s_axis_tuser),
        .i_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .i_out_data        (m_axis_tdata),
        .i_out_user        (m_axis_tuser),
        .i_out_last        (m_axis_tlast),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_answered_words  (answered_words),
        .o_results_checked (results_checked),
        .o_ids_found       (ids_found)
    );

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pack_word(input logic first, input logic [1:0] lows,
                                             input logic idb, input logic cmpb);
        return {3'b000, cmpb, idb, lows, first};
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            sink_hold     <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [1:0] fn, input logic [7:0] data);
        int gap;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_start(input logic first);
        send_word(FN_START, pack_word(first, 2'($urandom_range(0, 3)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_presence(input logic [1:0] lows);
        send_word(FN_PRESENCE, pack_word(1'($urandom_range(0, 1)), lows,
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))));
    endtask

    task automatic send_pair(input logic idb, input logic cmpb);
        send_word(FN_PAIR, pack_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                     idb, cmpb));
    endtask

    task automatic run_pairs(input int count, input int conflict_pct, input int break_pct,
                             input bit zero_family);
        int k;
        int r;
        for (k = 1; k <= count; k++) begin
            r = $urandom_range(0, 99);
            if (zero_family && k <= FAMILY_BITS) begin
                send_pair(1'b0, 1'b1);
            end else if (r < break_pct) begin
                send_pair(1'b1, 1'b1);
                return;
            end else if (r < break_pct + conflict_pct) begin
                send_pair(1'b0, 1'b0);
            end else if ($urandom_range(0, 1) == 1) begin
                send_pair(1'b1, 1'b0);
            end else begin
                send_pair(1'b0, 1'b1);
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int kind;
        int n;
        logic [1:0] lows;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of phase while idle
        send_pair(1'b1, 1'b0);
        send_presence(2'd1);
        send_word(FN_SPARE, 8'h1F);
        // bad presence counts, noise while waiting for presence
        send_start(1'b1);
        send_word(FN_SPARE, 8'h00);
        send_pair(1'b0, 1'b0);
        send_presence(2'd0);
        send_start(1'b0);
        send_presence(2'd2);
        send_start(1'b1);
        send_presence(2'd3);
        // 1/1 break, stray presence while searching
        send_start(1'b1);
        send_presence(2'd1);
        send_presence(2'd1);
        send_pair(1'b1, 1'b1);
        // restart in the middle of a search
        send_start(1'b0);
        send_presence(2'd1);
        send_pair(1'b1, 1'b0);
        send_pair(1'b0, 1'b0);
        send_pair(1'b0, 1'b1);
        send_start(1'b1);
        send_presence(2'd1);
        send_pair(1'b0, 1'b0);
        drain_results();

        // no conflicts: last device, then a next search after it
        send_start(1'b1);
        send_presence(2'd1);
        run_pairs(64, 0, 0, 1'b0);
        send_start(1'b0);
        // zero family byte
        send_start(1'b1);
        send_presence(2'd1);
        run_pairs(64, 35, 0, 1'b1);
        // first search, then a next search
        send_start(1'b1);
        send_presence(2'd1);
        run_pairs(64, 35, 0, 1'b0);
        send_start(1'b0);
        send_presence(2'd1);
        run_pairs(64, 35, 0, 1'b0);
        drain_results();

        while (answered_words < TARGET_WORDS) begin
            calm <= ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                send_start($urandom_range(0, 3) == 0);
                send_presence(2'd1);
                n = $urandom_range(0, 7);
                run_pairs(64, (n == 0) ? 0 : (n < 4) ? 15 : (n < 7) ? 40 : 70,
                          ($urandom_range(0, 4) == 0) ? 2 : 0, $urandom_range(0, 15) == 0);
            end else if (kind < 75) begin
                send_start(1'($urandom_range(0, 1)));
                lows = 2'($urandom_range(0, 2));
                if (lows == 2'd1)
                    lows = 2'd3;
                send_presence(lows);
            end else if (kind < 85) begin
                send_start(1'($urandom_range(0, 1)));
                send_presence(2'd1);
                run_pairs($urandom_range(1, 63), 35, 0, 1'b0);
            end else if (kind < 92) begin
                send_start(1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    n = $urandom_range(0, 2);
                    if (n == 0)
                        send_word(FN_SPARE, {3'b000, 5'($urandom)});
                    else if (n == 1)
                        send_presence(2'($urandom_range(0, 3)));
                    else
                        send_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d answered input words in %0d cycles", answered_words,
                 cycle_count);
        $display("Compared %0d result words, %0d searches reported an ID", results_checked,
                 ids_found);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
